// ----- hdl/image_window_convolution_top_defines.svh -----
// assertion macros shared by the block
`ifndef IMAGE_WINDOW_CONVOLUTION_TOP_DEFINES_SVH
`define IMAGE_WINDOW_CONVOLUTION_TOP_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define IWC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define IWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/iwc_pkg.sv -----
`default_nettype none

package iwc_pkg;

   localparam int KERNEL_BITS = 3;
   localparam int DIM_BITS = 13;
   localparam int HEIGHT_BITS = 11;
   localparam int MAX_HEIGHT = 1024;
   localparam int ROW_BITS = 10;
   localparam int POS_BITS = 10;
   localparam int RESULT_BITS = 32;
   localparam int KERNEL_REGS = 5;
   localparam int KROW_BITS = 60;
   localparam int COEF_SPAN_BITS = 64;

   // frame geometry after clamping
   typedef struct packed {
      logic [KERNEL_BITS-1:0] kernel;
      logic [DIM_BITS-1:0]    width;
      logic [HEIGHT_BITS-1:0] height;
   } geom_type;

   // position tag carried with each window
   typedef struct packed {
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] column;
      logic                last;
   } tag_type;

   typedef struct packed {
      logic signed [RESULT_BITS-1:0] value;
      tag_type                       tag;
   } result_type;

endpackage

`default_nettype wire

// ----- hdl/iwc_ram.sv -----
`default_nettype none

module iwc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/iwc_fifo.sv -----
`default_nettype none

module iwc_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty,
   output logic                  full,
   output logic      [CW-1:0]    count
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    head_ff, head_in;
   logic [PW-1:0]    tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));
   assign count   = count_ff;
   assign rdata   = slot_ff[head_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[tail_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/iwc_front.sv -----
`default_nettype none

module iwc_front
   import iwc_pkg::*;
#(
   parameter int MAX_KERNEL = 5,
   parameter int MAX_WIDTH = 1024,
   parameter int PIXEL_BITS = 16,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int WINW = MAX_KERNEL * MAX_KERNEL * PIXEL_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  restart,
   input  wire geom_type              geom,
   input  wire logic                  in_accept,
   input  wire logic [PIXEL_BITS-1:0] in_pixel,
   output logic                       busy,
   output logic                       win_push,
   output logic      [WINW-1:0]       win_data,
   output tag_type                    win_tag
);

   localparam int LS_ROWS = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int LSW = LS_ROWS * PIXEL_BITS;

   // raster position of the next pixel
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;

   // stage one: line store data returns, window shifts
   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [CW-1:0]         s1_addr_ff;
   logic                  s1_emit_ff;
   tag_type               s1_tag_ff;
   logic                  bypass_ff;
   logic [LSW-1:0]        wr_word_ff;
   logic [PIXEL_BITS-1:0] win_ff [MAX_KERNEL][MAX_KERNEL];
   logic [PIXEL_BITS-1:0] win_in [MAX_KERNEL][MAX_KERNEL];

   logic [DIM_BITS-1:0]    col_ext, row_ext, col_next, row_next, k_ext, half_ext;
   logic                   emit;
   tag_type                tag;
   logic [LSW-1:0]         rd_word, old_word, new_word;
   logic [PIXEL_BITS-1:0]  column [MAX_KERNEL];

   assign col_ext  = DIM_BITS'(col_ff);
   assign row_ext  = DIM_BITS'(row_ff);
   assign col_next = col_ext + 1'b1;
   assign row_next = row_ext + 1'b1;
   assign k_ext    = DIM_BITS'(geom.kernel);
   assign half_ext = DIM_BITS'(geom.kernel >> 1);

   assign emit       = (row_next >= k_ext) && (col_next >= k_ext);
   assign tag.row    = POS_BITS'(row_ext - half_ext);
   assign tag.column = POS_BITS'(col_ext - half_ext);
   assign tag.last   = (row_next == DIM_BITS'(geom.height)) && (col_next == geom.width);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (in_accept) begin
         if (col_next >= geom.width) begin
            col_in = '0;
            row_in = (row_next >= DIM_BITS'(geom.height)) ? '0 : row_next[ROW_BITS-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   iwc_ram #(
      .WIDTH (LSW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (new_word),
      .rd_en   (in_accept),
      .rd_addr (col_ff),
      .rd_data (rd_word)
   );

   // one-column rows write and read the same word back to back
   assign old_word = bypass_ff ? wr_word_ff : rd_word;

   always_comb begin
      column[0] = s1_pixel_ff;
      for (int i = 1; i < MAX_KERNEL; i++) begin
         column[i] = old_word[(i-1)*PIXEL_BITS +: PIXEL_BITS];
      end
      new_word = old_word;
      new_word[PIXEL_BITS-1:0] = s1_pixel_ff;
      for (int i = 1; i < LS_ROWS; i++) begin
         new_word[i*PIXEL_BITS +: PIXEL_BITS] = old_word[(i-1)*PIXEL_BITS +: PIXEL_BITS];
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
         for (int j = 0; j + 1 < MAX_KERNEL; j++) begin
            win_in[i][j] = win_ff[i][j+1];
         end
         win_in[i][MAX_KERNEL-1] = column[i];
      end
      for (int i = 0; i < MAX_KERNEL; i++) begin
         for (int j = 0; j < MAX_KERNEL; j++) begin
            win_data[(i*MAX_KERNEL+j)*PIXEL_BITS +: PIXEL_BITS] = win_in[i][j];
         end
      end
   end

   assign busy     = s1_valid_ff;
   assign win_push = s1_valid_ff && s1_emit_ff;
   assign win_tag  = s1_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         bypass_ff   <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= in_accept;
         bypass_ff   <= in_accept && s1_valid_ff && (s1_addr_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_pixel_ff <= in_pixel;
         s1_addr_ff  <= col_ff;
         s1_emit_ff  <= emit;
         s1_tag_ff   <= tag;
      end
      if (s1_valid_ff) begin
         wr_word_ff <= new_word;
         win_ff     <= win_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/iwc_back.sv -----
`default_nettype none

module iwc_back
   import iwc_pkg::*;
#(
   parameter int MAX_KERNEL = 5,
   parameter int PIXEL_BITS = 16,
   parameter int COEF_BITS = 12,
   localparam int WINW = MAX_KERNEL * MAX_KERNEL * PIXEL_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [KERNEL_BITS-1:0] kernel,
   input  wire logic [KROW_BITS-1:0]   kernel_rows [KERNEL_REGS],
   input  wire logic                   win_valid,
   input  wire logic [WINW-1:0]        win_data,
   input  wire tag_type                win_tag,
   output logic      [1:0]             inflight,
   output logic                        res_push,
   output result_type                  res_data
);

   localparam int IW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int PW = PIXEL_BITS + COEF_BITS;
   localparam int GROW = PW + $clog2(MAX_KERNEL * MAX_KERNEL) + 1;
   localparam int SW = (GROW > RESULT_BITS) ? GROW : RESULT_BITS + 1;
   localparam logic signed [SW-1:0] SAT_HI =
      {{(SW-RESULT_BITS+1){1'b0}}, {(RESULT_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO =
      {{(SW-RESULT_BITS+1){1'b1}}, {(RESULT_BITS-1){1'b0}}};

   logic [PIXEL_BITS-1:0]     win_pix [MAX_KERNEL][MAX_KERNEL];
   logic [COEF_SPAN_BITS-1:0] row64 [KERNEL_REGS];

   logic signed [PW-1:0] prod_ff [MAX_KERNEL][MAX_KERNEL];
   logic                 p1_valid_ff;
   tag_type              p1_tag_ff;
   logic signed [SW-1:0] row_sum_ff [MAX_KERNEL];
   logic signed [SW-1:0] row_sum_in [MAX_KERNEL];
   logic                 p2_valid_ff;
   tag_type              p2_tag_ff;
   logic signed [SW-1:0] total;
   logic signed [SW-1:0] clipped;

   always_comb begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
         for (int j = 0; j < MAX_KERNEL; j++) begin
            win_pix[i][j] = win_data[(i*MAX_KERNEL+j)*PIXEL_BITS +: PIXEL_BITS];
         end
      end
      for (int r = 0; r < KERNEL_REGS; r++) begin
         row64[r] = {{(COEF_SPAN_BITS-KROW_BITS){1'b0}}, kernel_rows[r]};
      end
   end

   // one multiplier per lane, lane (a,b) pairs kernel row a with window pixel
   // a rows below the window top and b columns right of its left edge
   for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_row
      for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_col
         logic signed [PIXEL_BITS-1:0] px;
         logic signed [COEF_BITS-1:0]  coef;

         if (a < KERNEL_REGS && (b + 1) * COEF_BITS <= COEF_SPAN_BITS) begin : g_coef
            assign coef = row64[a][b*COEF_BITS +: COEF_BITS];
         end else begin : g_zero
            assign coef = '0;
         end

         always_comb begin
            int ri;
            int ci;
            ri = int'(kernel) - 1 - a;
            ci = MAX_KERNEL - int'(kernel) + b;
            if (a < int'(kernel) && b < int'(kernel)) begin
               px = win_pix[ri[IW-1:0]][ci[IW-1:0]];
            end else begin
               px = '0;
            end
         end

         always_ff @(posedge clock) begin
            if (win_valid) begin
               prod_ff[a][b] <= px * coef;
            end
         end
      end
   end

   always_comb begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
         row_sum_in[a] = '0;
         for (int b = 0; b < MAX_KERNEL; b++) begin
            row_sum_in[a] = row_sum_in[a] + SW'(prod_ff[a][b]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int a = 0; a < MAX_KERNEL; a++) begin
         total = total + row_sum_ff[a];
      end
      if (total > SAT_HI) begin
         clipped = SAT_HI;
      end else if (total < SAT_LO) begin
         clipped = SAT_LO;
      end else begin
         clipped = total;
      end
   end

   assign inflight       = {1'b0, p1_valid_ff} + {1'b0, p2_valid_ff};
   assign res_push       = p2_valid_ff;
   assign res_data.value = clipped[RESULT_BITS-1:0];
   assign res_data.tag   = p2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= win_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (win_valid) begin
         p1_tag_ff <= win_tag;
      end
      if (p1_valid_ff) begin
         p2_tag_ff  <= p1_tag_ff;
         row_sum_ff <= row_sum_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/image_window_convolution_top.sv -----
// streaming 2d window filter over a raster-order pixel stream
// input side: a word is taken at a clock edge with push high and full low;
//   one pixel per word, rows left to right, frames top to bottom
// result side: while empty is low the oldest result sits on the rsp_ ports;
//   pop with empty low takes it. only interior pixels (where a full
//   kernel_size square window exists) give a result, tagged with the
//   row and column of the window centre and a frame_last flag
// throughput: one pixel per clock while full stays low, set by the single line store
//   port pair and the per-tap multiplier lanes
// path: the pixel that completes a window passes through the line store read and
//   window shift, the window queue, multiply, row sums, and final sum and clip
//   into the result queue, whose head sits on the rsp_ ports
// stalls: the window queue and the result queue absorb a stalled receiver;
//   full rises once the window queue, counting a word in stage one, has no room
// reset: synchronous, clears the raster position and both queues; kernel
//   size 3, 1024 x 1024 frame, all coefficients zero. line store contents
//   stay undefined, no clearing pass is needed
// configuration: apb-style 64-bit port, register i at byte address 8*i;
//   write only while idle. geometry writes restart the frame

`default_nettype none
`include "image_window_convolution_top_defines.svh"

module image_window_convolution_top
   import iwc_pkg::*;
#(
   parameter int MAX_KERNEL = 5,
   parameter int MAX_WIDTH = 1024,
   parameter int PIXEL_BITS = 16,
   parameter int COEF_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel input
   input  wire logic                   push,
   output logic                        full,
   input  wire logic [PIXEL_BITS-1:0]  req_pixel,
   // results
   input  wire logic                   pop,
   output logic                        empty,
   output logic      [RESULT_BITS-1:0] rsp_filtered_value,
   output logic      [POS_BITS-1:0]    rsp_out_row,
   output logic      [POS_BITS-1:0]    rsp_out_column,
   output logic                        rsp_frame_last,
   // configuration
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [5:0]             paddr,
   input  wire logic [63:0]            pwdata,
   output logic      [63:0]            prdata,
   output logic                        pready
);

   localparam int WINW = MAX_KERNEL * MAX_KERNEL * PIXEL_BITS;
   localparam int TAGW = $bits(tag_type);
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 8;
   localparam int MCW = $clog2(MID_DEPTH + 1);
   localparam int OCW = $clog2(OUT_DEPTH + 1);

   // register map, index = byte address / 8
   localparam logic [2:0] REG_KERNEL_SIZE  = 3'd0;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
   localparam logic [2:0] REG_ROW_ZERO     = 3'd3;
   localparam logic [2:0] REG_ROW_ONE      = 3'd4;
   localparam logic [2:0] REG_ROW_TWO      = 3'd5;
   localparam logic [2:0] REG_ROW_THREE    = 3'd6;
   localparam logic [2:0] REG_ROW_FOUR     = 3'd7;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [KERNEL_BITS-1:0] kernel_size_ff;
   logic [HEIGHT_BITS-1:0] image_width_ff;
   logic [HEIGHT_BITS-1:0] image_height_ff;
   logic [KROW_BITS-1:0]   kernel_row_ff [KERNEL_REGS];
   logic                   csr_write;
   logic [2:0]             csr_index;
   logic                   restart;
   geom_type               geom;
   logic [KERNEL_BITS-1:0] k_eff;
   logic [DIM_BITS-1:0]    w_raw;
   logic [DIM_BITS-1:0]    h_raw;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[5:3];
   // any write to the geometry registers starts a new frame
   assign restart   = csr_write && ((csr_index == REG_KERNEL_SIZE) ||
                                    (csr_index == REG_IMAGE_WIDTH) ||
                                    (csr_index == REG_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_size_ff  <= KERNEL_BITS'(3);
         image_width_ff  <= HEIGHT_BITS'(1024);
         image_height_ff <= HEIGHT_BITS'(1024);
         for (int r = 0; r < KERNEL_REGS; r++) begin
            kernel_row_ff[r] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_KERNEL_SIZE:  kernel_size_ff   <= pwdata[KERNEL_BITS-1:0];
            REG_IMAGE_WIDTH:  image_width_ff   <= pwdata[HEIGHT_BITS-1:0];
            REG_IMAGE_HEIGHT: image_height_ff  <= pwdata[HEIGHT_BITS-1:0];
            REG_ROW_ZERO:     kernel_row_ff[0] <= pwdata[KROW_BITS-1:0];
            REG_ROW_ONE:      kernel_row_ff[1] <= pwdata[KROW_BITS-1:0];
            REG_ROW_TWO:      kernel_row_ff[2] <= pwdata[KROW_BITS-1:0];
            REG_ROW_THREE:    kernel_row_ff[3] <= pwdata[KROW_BITS-1:0];
            REG_ROW_FOUR:     kernel_row_ff[4] <= pwdata[KROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_KERNEL_SIZE:  prdata = 64'(kernel_size_ff);
         REG_IMAGE_WIDTH:  prdata = 64'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = 64'(image_height_ff);
         REG_ROW_ZERO:     prdata = 64'(kernel_row_ff[0]);
         REG_ROW_ONE:      prdata = 64'(kernel_row_ff[1]);
         REG_ROW_TWO:      prdata = 64'(kernel_row_ff[2]);
         REG_ROW_THREE:    prdata = 64'(kernel_row_ff[3]);
         REG_ROW_FOUR:     prdata = 64'(kernel_row_ff[4]);
         default:          prdata = '0;
      endcase
   end

   // kernel side clamped to 1..MAX_KERNEL, even sides drop to the odd below
   always_comb begin
      k_eff = kernel_size_ff;
      if (k_eff == '0) begin
         k_eff = KERNEL_BITS'(1);
      end
      if (k_eff > KERNEL_BITS'(MAX_KERNEL)) begin
         k_eff = KERNEL_BITS'(MAX_KERNEL);
      end
      if (!k_eff[0]) begin
         k_eff = k_eff - 1'b1;
      end
   end

   // zero acts as one, oversize acts as the maximum
   always_comb begin
      w_raw = DIM_BITS'(image_width_ff);
      h_raw = DIM_BITS'(image_height_ff);
      if (w_raw == '0) begin
         w_raw = DIM_BITS'(1);
      end else if (w_raw > DIM_BITS'(MAX_WIDTH)) begin
         w_raw = DIM_BITS'(MAX_WIDTH);
      end
      if (h_raw == '0) begin
         h_raw = DIM_BITS'(1);
      end else if (h_raw > DIM_BITS'(MAX_HEIGHT)) begin
         h_raw = DIM_BITS'(MAX_HEIGHT);
      end
   end

   assign geom.kernel = k_eff;
   assign geom.width  = w_raw;
   assign geom.height = h_raw[HEIGHT_BITS-1:0];

   // ---------------------------------------------------------------------
   // front: line store and window
   // ---------------------------------------------------------------------
   logic            in_accept;
   logic            front_busy;
   logic            mid_push;
   logic [WINW-1:0] front_win;
   tag_type         front_tag;
   logic [MCW-1:0]  mid_count;
   logic [MCW:0]    mid_load;

   // credit check: a word still in stage one may need a queue slot
   assign mid_load  = {1'b0, mid_count} + (MCW + 1)'(front_busy);
   assign full      = (mid_load >= (MCW + 1)'(MID_DEPTH));
   assign in_accept = push && !full;

   iwc_front #(
      .MAX_KERNEL (MAX_KERNEL),
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .geom      (geom),
      .in_accept (in_accept),
      .in_pixel  (req_pixel),
      .busy      (front_busy),
      .win_push  (mid_push),
      .win_data  (front_win),
      .win_tag   (front_tag)
   );

   // ---------------------------------------------------------------------
   // window queue between front and back
   // ---------------------------------------------------------------------
   logic [WINW+TAGW-1:0] mid_rdata;
   logic                 mid_empty;
   logic                 mid_full;
   logic                 mid_pop;
   logic [WINW-1:0]      back_win;
   tag_type              back_tag;

   iwc_fifo #(
      .WIDTH (WINW + TAGW),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata ({front_win, front_tag}),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty),
      .full  (mid_full),
      .count (mid_count)
   );

   assign back_win = mid_rdata[WINW+TAGW-1:TAGW];
   assign back_tag = tag_type'(mid_rdata[TAGW-1:0]);

   // ---------------------------------------------------------------------
   // back: multiply lanes and adder tree
   // ---------------------------------------------------------------------
   logic [1:0]     back_inflight;
   logic           out_push;
   result_type     back_result;
   logic [OCW-1:0] out_count;
   logic [OCW:0]   out_load;

   // a window leaves the queue only when its result has a slot waiting
   assign out_load = {1'b0, out_count} + (OCW + 1)'(back_inflight);
   assign mid_pop  = !mid_empty && (out_load < (OCW + 1)'(OUT_DEPTH));

   iwc_back #(
      .MAX_KERNEL (MAX_KERNEL),
      .PIXEL_BITS (PIXEL_BITS),
      .COEF_BITS  (COEF_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .kernel      (k_eff),
      .kernel_rows (kernel_row_ff),
      .win_valid   (mid_pop),
      .win_data    (back_win),
      .win_tag     (back_tag),
      .inflight    (back_inflight),
      .res_push    (out_push),
      .res_data    (back_result)
   );

   // ---------------------------------------------------------------------
   // result queue
   // ---------------------------------------------------------------------
   result_type out_head;
   logic       out_full;
   logic       out_pop;

   assign out_pop = pop && !empty;

   iwc_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (back_result),
      .pop   (out_pop),
      .rdata (out_head),
      .empty (empty),
      .full  (out_full),
      .count (out_count)
   );

   assign rsp_filtered_value = out_head.value;
   assign rsp_out_row        = out_head.tag.row;
   assign rsp_out_column     = out_head.tag.column;
   assign rsp_frame_last     = out_head.tag.last;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // input credit keeps the window queue from overflowing
   `IWC_ASSERT_IMPLY(a_mid_no_overflow, clock, reset, mid_push, !mid_full, "window queue overflow")
   // result credit keeps the result queue from overflowing
   `IWC_ASSERT_IMPLY(a_out_no_overflow, clock, reset, out_push, !out_full, "result queue overflow")
   // a window taken by the back end is counted as in flight next cycle
   `IWC_ASSERT_NEXT(a_back_tracks, clock, reset, mid_pop, back_inflight != 2'd0, "lost in-flight window")

endmodule

`default_nettype wire
